// ===== rtl/cbt_pkg.sv =====
`timescale 1ns / 1ps
package cbt_pkg;
  localparam int MaxKeys  = 1024;
  localparam int KeyBytes = 5;
  localparam int KeyBits  = 8 * KeyBytes;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = IdxW + 1;
  localparam int PosW     = $clog2(KeyBits);
  localparam int LinkW    = IdxW + 1;
  localparam int NodeW    = 2 * LinkW + PosW;
  localparam logic [7:0] ByteMask = 8'd255;

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [LinkW-1:0]   link_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [PosW-1:0]    pos_t;

  typedef struct packed {
    link_t child1;
    link_t child0;
    pos_t  pos;
  } node_t;

  typedef enum logic [2:0] {
    StInserted  = 3'd0,
    StDuplicate = 3'd1,
    StFound     = 3'd2,
    StNotFound  = 3'd3,
    StFull      = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    OpInsert = 1'b0,
    OpLookup = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DREQ, S_DWAIT, S_LREQ, S_LWAIT, S_DIFF,
    S_WREQ, S_WWAIT, S_SPLICE, S_OUT
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;       // capture incoming item
    logic node_step;  // follow child of read node
    logic diff_step;  // scan one byte for first difference
    logic walk_init;  // restart walk from root
    logic walk_step;  // follow child during splice walk
    logic splice;     // write leaf, node, parent link
    logic first;      // store first key in empty tree
    logic set_result; // latch status computed in datapath
  } cmd_t;

  // Datapath status back to controller
  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic full;
    logic link_inner;
    logic node_stop;  // read node tests a later bit than the split
    logic keys_equal;
    logic diff_done;
  } sts_t;

  function automatic logic key_bit(key_t k, pos_t p);
    return k[KeyBits-1-int'(p)];
  endfunction
endpackage

// ===== rtl/critbit_trie_insert_lookup_core.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | opcode_i, key_value_i
// out     | output    | out_valid_o/out_stall_i | status_o, leaf_index_o
// One item at a time. Lookup: descent through the tree levels, then leaf read and compare.
// Insert: descent, leaf compare, scan of one key byte per cycle for the first difference,
// second walk from the root, splice.
// The registered read of the node memory sets the per-level cost.
// Reset clears root and key count; memories need no clearing pass.
// A stalled result holds; the next item waits until it is taken.
module critbit_trie_insert_lookup_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [39:0]                 key_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [9:0]                  leaf_index_o
);
  import cbt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cbt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  cbt_dp u_dp (
    .clk_i, .rst_ni, .opcode_i, .key_value_i, .cmd_i(cmd), .sts_o(sts),
    .status_o, .leaf_index_o
  );
endmodule

// ===== rtl/cbt_ram.sv =====
`timescale 1ns / 1ps
module cbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/cbt_ctrl.sv =====
`timescale 1ns / 1ps
module cbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  cbt_pkg::sts_t sts_i,
  output cbt_pkg::cmd_t cmd_o
);
  import cbt_pkg::*;

  state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DREQ;
      S_DREQ: begin
        if (sts_i.empty) state_d = S_OUT;
        else if (sts_i.link_inner) state_d = S_DWAIT;
        else state_d = S_LREQ;
      end
      S_DWAIT: state_d = S_DREQ;
      S_LREQ:  state_d = S_LWAIT;
      S_LWAIT: begin
        if (sts_i.keys_equal || sts_i.is_lookup || sts_i.full) state_d = S_OUT;
        else state_d = S_DIFF;
      end
      S_DIFF:  if (sts_i.diff_done) state_d = S_WREQ;
      S_WREQ:  state_d = sts_i.link_inner ? S_WWAIT : S_SPLICE;
      S_WWAIT: state_d = sts_i.node_stop ? S_SPLICE : S_WREQ;
      S_SPLICE: state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      S_DREQ: begin
        cmd_o.first   = sts_i.empty && !sts_i.is_lookup;
        cmd_o.set_result = sts_i.empty;
      end
      S_DWAIT:  cmd_o.node_step = 1'b1;
      S_LREQ:   ;
      S_LWAIT:  cmd_o.set_result = 1'b1;
      S_DIFF: begin
        cmd_o.diff_step = 1'b1;
        cmd_o.walk_init = sts_i.diff_done;
      end
      S_WREQ:   ;
      S_WWAIT:  cmd_o.walk_step = !sts_i.node_stop;
      S_SPLICE: cmd_o.splice = 1'b1;
      S_OUT:    out_valid_o = 1'b1;
      default:  ;
    endcase
  end
endmodule

// ===== rtl/cbt_dp.sv =====
`timescale 1ns / 1ps
module cbt_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    opcode_i,
  input  logic [cbt_pkg::KeyBits-1:0] key_value_i,
  input  cbt_pkg::cmd_t           cmd_i,
  output cbt_pkg::sts_t           sts_o,
  output logic [2:0]              status_o,
  output logic [cbt_pkg::IdxW-1:0] leaf_index_o
);
  import cbt_pkg::*;

  localparam int ByteW = $clog2(KeyBytes + 1);

  logic      op_q;
  key_t      key_q;
  link_t     root_q, root_d;
  logic [CntW-1:0] count_q, count_d;
  link_t     link_q, link_d;
  // parent: par_root set = root register, else node index and side
  logic      par_root_q, par_root_d;
  idx_t      par_idx_q, par_idx_d;
  logic      par_side_q, par_side_d;
  pos_t      dpos_q, dpos_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic      done_q, done_d;
  logic [2:0] res_st_q, res_st_d;
  idx_t      res_idx_q, res_idx_d;
  node_t     node_rd;
  key_t      leaf_rd;
  logic      nb;

  // Node store write port: splice writes the new node, then patches parent
  logic      n_we;
  idx_t      n_wa, n_ra;
  node_t     n_wd;
  logic      k_we;
  logic      patch_q;
  node_t     patch_node_q;

  // Shadow copy of last read node so the parent patch can rewrite it
  assign nb = key_bit(key_q, node_rd.pos);
  assign n_ra = link_q[LinkW-1:1];

  always_comb begin
    n_we = 1'b0; n_wa = par_idx_q; n_wd = patch_node_q;
    if (cmd_i.splice) begin
      n_we = 1'b1;
      n_wa = count_q[IdxW-1:0];
      n_wd.pos = dpos_q;
      if (key_bit(key_q, dpos_q)) begin
        n_wd.child1 = {count_q[IdxW-1:0], 1'b0};
        n_wd.child0 = link_q;
      end else begin
        n_wd.child0 = {count_q[IdxW-1:0], 1'b0};
        n_wd.child1 = link_q;
      end
    end else if (patch_q) begin
      n_we = 1'b1;
    end
  end

  assign k_we = cmd_i.splice || cmd_i.first;

  cbt_ram #(.Width(NodeW), .Depth(MaxKeys)) u_nodes (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd),
    .raddr_i(n_ra), .rdata_o(node_rd)
  );

  cbt_ram #(.Width(KeyBits), .Depth(MaxKeys)) u_leaves (
    .clk_i, .we_i(k_we),
    .waddr_i(cmd_i.first ? idx_t'(0) : count_q[IdxW-1:0]),
    .wdata_i(key_q), .raddr_i(link_q[LinkW-1:1]), .rdata_o(leaf_rd)
  );

  // Status to the controller
  always_comb begin
    sts_o.is_lookup  = op_q == OpLookup;
    sts_o.empty      = count_q == '0;
    sts_o.full       = count_q >= CntW'(MaxKeys);
    sts_o.link_inner = link_q[0];
    sts_o.node_stop  = node_rd.pos > dpos_q;
    sts_o.keys_equal = leaf_rd == key_q;
    sts_o.diff_done  = done_q;
  end

  // Datapath next values
  always_comb begin
    logic [7:0] xb;
    logic       hit;
    logic [2:0] bp;
    root_d = root_q; count_d = count_q; link_d = link_q;
    par_root_d = par_root_q; par_idx_d = par_idx_q; par_side_d = par_side_q;
    dpos_d = dpos_q; byte_d = byte_q; done_d = done_q;
    res_st_d = res_st_q; res_idx_d = res_idx_q;
    xb = '0; hit = 1'b0; bp = '0;
    if (cmd_i.load) begin
      link_d = root_q;
      byte_d = '0;
      done_d = 1'b0;
    end
    if (cmd_i.node_step) link_d = nb ? node_rd.child1 : node_rd.child0;
    if (cmd_i.first) begin
      root_d = '0;
      count_d = CntW'(1);
    end
    if (cmd_i.set_result) begin
      res_idx_d = '0;
      if (count_q == '0) begin
        res_st_d = (op_q == OpLookup) ? StNotFound : StInserted;
      end else if (leaf_rd == key_q) begin
        res_st_d = (op_q == OpLookup) ? StFound : StDuplicate;
        res_idx_d = link_q[LinkW-1:1];
      end else if (op_q == OpLookup) begin
        res_st_d = StNotFound;
      end else if (count_q >= CntW'(MaxKeys)) begin
        res_st_d = StFull;
      end else begin
        res_st_d = StInserted;
        res_idx_d = count_q[IdxW-1:0];
      end
    end
    // Scan one byte a cycle for the highest differing bit
    if (cmd_i.diff_step && !done_q) begin
      xb = (key_q[KeyBits-1-8*int'(byte_q) -: 8] ^
            leaf_rd[KeyBits-1-8*int'(byte_q) -: 8]) & ByteMask;
      for (int i = 0; i < 8; i++) begin
        if (!hit && xb[7-i]) begin
          hit = 1'b1;
          bp = 3'(i);
        end
      end
      if (hit || byte_q == ByteW'(KeyBytes - 1)) begin
        done_d = 1'b1;
        dpos_d = PosW'(8 * int'(byte_q) + (hit ? int'(bp) : 7));
      end
      byte_d = byte_q + 1'b1;
    end
    if (cmd_i.walk_init) begin
      link_d = root_q;
      par_root_d = 1'b1;
    end
    if (cmd_i.walk_step) begin
      link_d = nb ? node_rd.child1 : node_rd.child0;
      par_root_d = 1'b0;
      par_idx_d = link_q[LinkW-1:1];
      par_side_d = nb;
    end
    if (cmd_i.splice) begin
      count_d = count_q + 1'b1;
      if (par_root_q) root_d = {count_q[IdxW-1:0], 1'b1};
    end
  end

  // Control and tree registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      count_q <= '0;
      patch_q <= 1'b0;
    end else begin
      root_q  <= root_d;
      count_q <= count_d;
      patch_q <= cmd_i.splice && !par_root_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_value_i;
    end
    link_q <= link_d;
    par_root_q <= par_root_d;
    par_idx_q <= par_idx_d;
    par_side_q <= par_side_d;
    dpos_q <= dpos_d;
    byte_q <= byte_d;
    done_q <= done_d;
    res_st_q <= res_st_d;
    res_idx_q <= res_idx_d;
    // Keep parent node with its child link redirected to the new node
    if (cmd_i.walk_step) patch_node_q <= node_rd;
    if (cmd_i.splice) begin
      if (par_side_q) patch_node_q.child1 <= {count_q[IdxW-1:0], 1'b1};
      else            patch_node_q.child0 <= {count_q[IdxW-1:0], 1'b1};
    end
  end

  assign status_o     = res_st_q;
  assign leaf_index_o = res_idx_q;
endmodule

// ===== rtl/cbt_checker.sv =====
`timescale 1ns / 1ps
module cbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [9:0] leaf_index_o
);
  import cbt_pkg::*;

  // Status code stays in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StFull) else $error("bad status");
  // No input taken while a result is pending
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("overlap");
  // Not-found and full carry slot zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StNotFound || status_o == StFull)) |-> leaf_index_o == '0)
    else $error("slot not zero");
  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
endmodule

bind critbit_trie_insert_lookup_core cbt_checker u_chk (.*);
